// ===== rtl/fctex_pkg.sv =====
// shared types, constants and helper functions of the floor texel address unit
package fctex_pkg;

    localparam int COORD_BITS = 12;

    localparam int ROW_W     = 12;
    localparam int TRIG_W    = 16;
    localparam int TRIG_FRAC = 14;
    localparam int POS_W     = 24;
    localparam int FRAC_BITS = 8;
    localparam int EYE_W     = 11;
    localparam int HB_W      = 16;
    localparam int PD_W      = 16;
    localparam int HOR_W     = 12;
    localparam int TEX_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int DEN_W     = 14;
    localparam int DDIV_W    = DEN_W - 1;
    localparam int PROD_W    = HB_W + PD_W;
    localparam int DIST_W    = 24;
    localparam int HI_SHIFT  = DIST_W - FRAC_BITS;
    localparam int HI_W      = PROD_W - HI_SHIFT;

    localparam int MDIV_W    = COORD_BITS + 1;
    localparam int REM_W     = (DDIV_W > MDIV_W) ? DDIV_W : MDIV_W;
    localparam int STEPS     = 4;
    localparam int DIV_STG   = (DIST_W + STEPS - 1) / STEPS;

    localparam int MAC_W     = DIST_W + 1 + TRIG_W;
    localparam int Q_SHIFT   = TRIG_FRAC + FRAC_BITS;
    localparam int FL_W      = MAC_W - Q_SHIFT;
    localparam int MOD_STG   = (FL_W + STEPS - 1) / STEPS;
    localparam int MAG_W     = MOD_STG * STEPS;
    localparam int TEX_LIM   = 1 << COORD_BITS;

    localparam logic [HB_W-1:0]  HB_RST  = 16'd32;
    localparam logic [PD_W-1:0]  PD_RST  = 16'd277;
    localparam logic [HOR_W-1:0] HOR_RST = 12'd240;
    localparam logic [TEX_W-1:0] TEX_RST = 13'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_BLOCK = 3'd0,
        CFG_PROJ_DIST  = 3'd1,
        CFG_HORIZON    = 3'd2,
        CFG_TEX_WIDTH  = 3'd3,
        CFG_TEX_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [HB_W-1:0]  half_block;
        logic [PD_W-1:0]  projection_distance;
        logic [HOR_W-1:0] horizon_offset;
        logic [TEX_W-1:0] texture_width;
        logic [TEX_W-1:0] texture_height;
    } t_cfg;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
    } t_rc;

    typedef struct packed {
        t_rc  rc;
        logic ok;
    } t_meta;

    typedef struct packed {
        logic [TRIG_W-1:0] cosine;
        logic [TRIG_W-1:0] sine;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
    } t_ray;

    typedef struct packed {
        t_meta meta;
        t_ray  ray;
    } t_side;

    // restoring divider working set: quotient bits shift in where dividend bits leave
    typedef struct packed {
        logic              sat;
        logic [REM_W-1:0]  rem;
        logic [DIST_W-1:0] nq;
        logic [REM_W-1:0]  dvs;
    } t_divw;

    typedef struct packed {
        logic             neg;
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] mag;
    } t_modw;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [REM_W:0] fn_rstep(input logic [REM_W-1:0] rem,
                                                input logic             din,
                                                input logic [REM_W-1:0] dvs);
        logic [REM_W:0] t;
        logic [REM_W:0] d;
        t = {rem, din};
        d = {1'b0, dvs};
        if (t >= d) begin
            t = t - d;
            return {1'b1, t[REM_W-1:0]};
        end
        return {1'b0, t[REM_W-1:0]};
    endfunction

    // zero acts as one, anything above the coordinate range is clamped
    function automatic logic [MDIV_W-1:0] fn_clamp_size(input logic [TEX_W-1:0] size);
        logic [31:0] s;
        s = 32'(size);
        if (s == 32'd0) begin
            s = 32'd1;
        end else if (s > 32'(TEX_LIM)) begin
            s = 32'(TEX_LIM);
        end
        return s[MDIV_W-1:0];
    endfunction

endpackage

// ===== rtl/fctex_pix_if.sv =====
// input channel: one floor pixel per transaction
interface fctex_pix_if;
    logic                                valid;
    logic                                ready;
    logic [fctex_pkg::ROW_W-1:0]         screen_row;
    logic [fctex_pkg::ROW_W-1:0]         screen_column;
    logic signed [fctex_pkg::TRIG_W-1:0] ray_cosine;
    logic signed [fctex_pkg::TRIG_W-1:0] ray_sine;
    logic [fctex_pkg::POS_W-1:0]         player_x;
    logic [fctex_pkg::POS_W-1:0]         player_y;
    logic signed [fctex_pkg::EYE_W-1:0]  eye_height;

    modport source (output valid, output screen_row, output screen_column,
                    output ray_cosine, output ray_sine, output player_x,
                    output player_y, output eye_height, input ready);
    modport sink   (input valid, input screen_row, input screen_column,
                    input ray_cosine, input ray_sine, input player_x,
                    input player_y, input eye_height, output ready);
endinterface

// ===== rtl/fctex_cfg_if.sv =====
// configuration write channel
interface fctex_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fctex_pkg::CFG_IDX_W-1:0]   index;
    logic [fctex_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fctex_tex_if.sv =====
// result channel: one texel address per transaction
interface fctex_tex_if;
    logic                             valid;
    logic                             ready;
    logic [fctex_pkg::ROW_W-1:0]      out_row;
    logic [fctex_pkg::ROW_W-1:0]      out_column;
    logic [fctex_pkg::COORD_BITS-1:0] texel_x;
    logic [fctex_pkg::COORD_BITS-1:0] texel_y;
    logic                             texel_valid;

    modport source (output valid, output out_row, output out_column, output texel_x,
                    output texel_y, output texel_valid, input ready);
    modport sink   (input valid, input out_row, input out_column, input texel_x,
                    input texel_y, input texel_valid, output ready);
endinterface

// ===== rtl/floor_cast_texel_address_unit.sv =====
// top level of the floor texel address unit: configuration registers and pipeline
// Takes one floor pixel per clock and returns one texel address per pixel in the same order.
// Throughput is one transaction per cycle while the output is not stalled. The pipeline
// holds two setup stages, the restoring divider for the floor distance (six stages, four
// quotient bits each), two multiply and accumulate stages, one sign stage, the restoring
// remainder unit for the texture wrap (five stages, four bits each) and the output register.
// Every stage has its own valid bit, so bubbles close up while the output is stalled.
// Configuration writes are always accepted and must only happen while the pipeline is empty.
module floor_cast_texel_address_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fctex_pix_if.sink     i_pix,
    fctex_cfg_if.sink     i_cfg,
    fctex_tex_if.source   o_tex
);
    fctex_pkg::t_cfg   r_cfg;

    fctex_pkg::t_side  w_in_side;
    logic              w_f_valid;
    logic              w_f_ready;
    fctex_pkg::t_side  w_f_side;
    fctex_pkg::t_divw  w_f_divw;
    logic              w_d_valid;
    logic              w_d_ready;
    fctex_pkg::t_side  w_d_side;
    logic [fctex_pkg::DIST_W-1:0]      w_d_dist;
    logic              w_w_valid;
    logic              w_w_ready;
    fctex_pkg::t_meta  w_w_meta;
    logic signed [fctex_pkg::FL_W-1:0] w_w_fx;
    logic signed [fctex_pkg::FL_W-1:0] w_w_fy;
    fctex_pkg::t_meta  w_o_meta;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_block          <= fctex_pkg::HB_RST;
            r_cfg.projection_distance <= fctex_pkg::PD_RST;
            r_cfg.horizon_offset      <= fctex_pkg::HOR_RST;
            r_cfg.texture_width       <= fctex_pkg::TEX_RST;
            r_cfg.texture_height      <= fctex_pkg::TEX_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                fctex_pkg::CFG_HALF_BLOCK: begin
                    r_cfg.half_block <= i_cfg.data[fctex_pkg::HB_W-1:0];
                end
                fctex_pkg::CFG_PROJ_DIST: begin
                    r_cfg.projection_distance <= i_cfg.data[fctex_pkg::PD_W-1:0];
                end
                fctex_pkg::CFG_HORIZON: begin
                    r_cfg.horizon_offset <= i_cfg.data[fctex_pkg::HOR_W-1:0];
                end
                fctex_pkg::CFG_TEX_WIDTH: begin
                    r_cfg.texture_width <= i_cfg.data[fctex_pkg::TEX_W-1:0];
                end
                fctex_pkg::CFG_TEX_HEIGHT: begin
                    r_cfg.texture_height <= i_cfg.data[fctex_pkg::TEX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_in_side.meta.rc.row = i_pix.screen_row;
        w_in_side.meta.rc.col = i_pix.screen_column;
        w_in_side.meta.ok     = 1'b0;
        w_in_side.ray.cosine  = i_pix.ray_cosine;
        w_in_side.ray.sine    = i_pix.ray_sine;
        w_in_side.ray.px      = i_pix.player_x;
        w_in_side.ray.py      = i_pix.player_y;
    end

    fctex_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_side  (w_in_side),
        .i_eye   (i_pix.eye_height),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_side  (w_f_side),
        .o_divw  (w_f_divw)
    );

    fctex_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_side  (w_f_side),
        .i_divw  (w_f_divw),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_side  (w_d_side),
        .o_dist  (w_d_dist)
    );

    fctex_world u_world (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_side  (w_d_side),
        .i_dist  (w_d_dist),
        .o_valid (w_w_valid),
        .i_ready (w_w_ready),
        .o_meta  (w_w_meta),
        .o_fx    (w_w_fx),
        .o_fy    (w_w_fy)
    );

    fctex_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_w_valid),
        .o_ready (w_w_ready),
        .i_meta  (w_w_meta),
        .i_fx    (w_w_fx),
        .i_fy    (w_w_fy),
        .o_valid (o_tex.valid),
        .i_ready (o_tex.ready),
        .o_meta  (w_o_meta),
        .o_tx    (o_tex.texel_x),
        .o_ty    (o_tex.texel_y)
    );

    assign o_tex.out_row     = w_o_meta.rc.row;
    assign o_tex.out_column  = w_o_meta.rc.col;
    assign o_tex.texel_valid = w_o_meta.ok;

    // pixels above the horizon carry zero coordinates
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tex.valid && !o_tex.texel_valid) |-> (o_tex.texel_x == '0 && o_tex.texel_y == '0))
        else $error("invalid texel with nonzero coordinates");

    // wrapped coordinates stay below the clamped texture size
    a_texel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tex.valid |-> ({1'b0, o_tex.texel_x} < fctex_pkg::fn_clamp_size(r_cfg.texture_width)
                      && {1'b0, o_tex.texel_y} < fctex_pkg::fn_clamp_size(r_cfg.texture_height)))
        else $error("texel coordinate outside texture");

    // input backpressure only when the whole pipeline is full behind a stalled output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (o_tex.valid && !o_tex.ready))
        else $error("input stalled while output can move");
endmodule

// ===== rtl/fctex_front.sv =====
// denominator, numerator product and divider setup (two stages)
module fctex_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fctex_pkg::t_cfg                     i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  fctex_pkg::t_side                    i_side,
    input  logic signed [fctex_pkg::EYE_W-1:0]  i_eye,
    output logic                                o_valid,
    input  logic                                i_ready,
    output fctex_pkg::t_side                    o_side,
    output fctex_pkg::t_divw                    o_divw
);
    localparam int DW = fctex_pkg::DEN_W;
    localparam int RW = fctex_pkg::REM_W;
    localparam int HW = fctex_pkg::HI_W;
    localparam int PW = fctex_pkg::PROD_W;
    localparam int SH = fctex_pkg::HI_SHIFT;
    localparam int FB = fctex_pkg::FRAC_BITS;
    localparam int DD = fctex_pkg::DDIV_W;

    logic                   r_a_v;
    fctex_pkg::t_side       r_a_side;
    logic signed [DW-1:0]   r_a_den;
    logic [PW-1:0]          r_a_prod;
    logic                   r_b_v;
    fctex_pkg::t_side       r_b_side;
    fctex_pkg::t_divw       r_b_w;

    logic                   w_rdy_a;
    logic                   w_rdy_b;
    logic signed [DW-1:0]   w_row_s;
    logic signed [DW-1:0]   w_eye_s;
    logic signed [DW-1:0]   w_hor_s;
    logic signed [DW-1:0]   n_den;
    logic [PW-1:0]          n_prod;
    logic [HW-1:0]          w_hi;
    logic [HW-1:0]          w_den_z;
    logic                   n_ok;
    fctex_pkg::t_divw       n_w;
    fctex_pkg::t_side       n_side;

    assign w_rdy_b = !r_b_v || i_ready;
    assign w_rdy_a = !r_a_v || w_rdy_b;
    assign o_ready = w_rdy_a;

    assign w_row_s = $signed(DW'(i_side.meta.rc.row));
    assign w_eye_s = DW'(i_eye);
    assign w_hor_s = $signed(DW'(i_cfg.horizon_offset));
    assign n_den   = w_row_s - w_eye_s - w_hor_s;
    assign n_prod  = i_cfg.half_block * i_cfg.projection_distance;

    // quotient overflows 24 bits exactly when the top product half reaches the divisor
    assign w_hi    = r_a_prod[PW-1:SH];
    assign w_den_z = HW'(r_a_den[DD-1:0]);
    assign n_ok    = r_a_den > 0;

    always_comb begin
        n_w.sat = w_hi >= w_den_z;
        n_w.rem = RW'(w_hi);
        n_w.nq  = {r_a_prod[SH-1:0], {FB{1'b0}}};
        n_w.dvs = RW'(r_a_den[DD-1:0]);
    end

    always_comb begin
        n_side         = r_a_side;
        n_side.meta.ok = n_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_v <= i_valid;
            end
            if (w_rdy_b) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_a_side <= i_side;
            r_a_den  <= n_den;
            r_a_prod <= n_prod;
        end
        if (w_rdy_b && r_a_v) begin
            r_b_side <= n_side;
            r_b_w    <= n_w;
        end
    end

    assign o_valid = r_b_v;
    assign o_side  = r_b_side;
    assign o_divw  = r_b_w;
endmodule

// ===== rtl/fctex_div.sv =====
// pipelined restoring divider, four quotient bits per stage, saturating output
module fctex_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  fctex_pkg::t_side                  i_side,
    input  fctex_pkg::t_divw                  i_divw,
    output logic                              o_valid,
    input  logic                              i_ready,
    output fctex_pkg::t_side                  o_side,
    output logic [fctex_pkg::DIST_W-1:0]      o_dist
);
    localparam int NS = fctex_pkg::DIV_STG;
    localparam int NB = fctex_pkg::STEPS;
    localparam int RW = fctex_pkg::REM_W;
    localparam int QW = fctex_pkg::DIST_W;

    logic [NS-1:0]     r_v;
    fctex_pkg::t_side  r_side [NS];
    fctex_pkg::t_divw  r_w    [NS];

    logic [NS:0]       w_rdy;
    logic [NS-1:0]     w_v_src;
    fctex_pkg::t_side  w_s_src [NS];
    fctex_pkg::t_divw  w_w_src [NS];
    fctex_pkg::t_divw  n_w     [NS];

    assign w_v_src    = {r_v[NS-2:0], i_valid};
    assign w_s_src[0] = i_side;
    assign w_w_src[0] = i_divw;
    for (genvar k = 1; k < NS; k++) begin : g_src
        assign w_s_src[k] = r_side[k-1];
        assign w_w_src[k] = r_w[k-1];
    end

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end
    assign o_ready = w_rdy[0];

    always_comb begin
        fctex_pkg::t_divw cur;
        logic [RW:0]      st;
        for (int k = 0; k < NS; k++) begin
            cur = w_w_src[k];
            for (int j = 0; j < NB; j++) begin
                st      = fctex_pkg::fn_rstep(cur.rem, cur.nq[QW-1], cur.dvs);
                cur.rem = st[RW-1:0];
                cur.nq  = {cur.nq[QW-2:0], st[RW]};
            end
            n_w[k] = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_v_src[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (w_rdy[k] && w_v_src[k]) begin
                r_side[k] <= w_s_src[k];
                r_w[k]    <= n_w[k];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_side  = r_side[NS-1];
    assign o_dist  = r_w[NS-1].sat ? {QW{1'b1}} : r_w[NS-1].nq;
endmodule

// ===== rtl/fctex_world.sv =====
// world point: distance times direction plus position, floored to integer (two stages)
module fctex_world (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  fctex_pkg::t_side                     i_side,
    input  logic [fctex_pkg::DIST_W-1:0]         i_dist,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output fctex_pkg::t_meta                     o_meta,
    output logic signed [fctex_pkg::FL_W-1:0]    o_fx,
    output logic signed [fctex_pkg::FL_W-1:0]    o_fy
);
    localparam int MW  = fctex_pkg::MAC_W;
    localparam int PW  = fctex_pkg::POS_W;
    localparam int TF  = fctex_pkg::TRIG_FRAC;
    localparam int QS  = fctex_pkg::Q_SHIFT;
    localparam int PAD = MW - PW - TF;

    logic                 r_c_v;
    fctex_pkg::t_meta     r_c_meta;
    logic [PW-1:0]        r_c_px;
    logic [PW-1:0]        r_c_py;
    logic signed [MW-1:0] r_c_mx;
    logic signed [MW-1:0] r_c_my;
    logic                 r_d_v;
    fctex_pkg::t_meta     r_d_meta;
    logic signed [MW-QS-1:0] r_d_fx;
    logic signed [MW-QS-1:0] r_d_fy;

    logic                 w_rdy_c;
    logic                 w_rdy_d;
    logic signed [MW-1:0] n_mx;
    logic signed [MW-1:0] n_my;
    logic signed [MW-1:0] w_pxs;
    logic signed [MW-1:0] w_pys;
    logic signed [MW-1:0] n_wx;
    logic signed [MW-1:0] n_wy;

    assign w_rdy_d = !r_d_v || i_ready;
    assign w_rdy_c = !r_c_v || w_rdy_d;
    assign o_ready = w_rdy_c;

    assign n_mx = $signed({1'b0, i_dist}) * $signed(i_side.ray.cosine);
    assign n_my = $signed({1'b0, i_dist}) * $signed(i_side.ray.sine);

    assign w_pxs = $signed({{PAD{1'b0}}, r_c_px, {TF{1'b0}}});
    assign w_pys = $signed({{PAD{1'b0}}, r_c_py, {TF{1'b0}}});
    assign n_wx  = r_c_mx + w_pxs;
    assign n_wy  = r_c_my + w_pys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (w_rdy_c) begin
                r_c_v <= i_valid;
            end
            if (w_rdy_d) begin
                r_d_v <= r_c_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_c && i_valid) begin
            r_c_meta <= i_side.meta;
            r_c_px   <= i_side.ray.px;
            r_c_py   <= i_side.ray.py;
            r_c_mx   <= n_mx;
            r_c_my   <= n_my;
        end
        // upper bits of a two's complement value are its floor
        if (w_rdy_d && r_c_v) begin
            r_d_meta <= r_c_meta;
            r_d_fx   <= n_wx[MW-1:QS];
            r_d_fy   <= n_wy[MW-1:QS];
        end
    end

    assign o_valid = r_d_v;
    assign o_meta  = r_d_meta;
    assign o_fx    = r_d_fx;
    assign o_fy    = r_d_fy;
endmodule

// ===== rtl/fctex_wrap.sv =====
// floored modulo of both coordinates by the texture size, pipelined restoring remainder
module fctex_wrap (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fctex_pkg::t_cfg                      i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  fctex_pkg::t_meta                     i_meta,
    input  logic signed [fctex_pkg::FL_W-1:0]    i_fx,
    input  logic signed [fctex_pkg::FL_W-1:0]    i_fy,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output fctex_pkg::t_meta                     o_meta,
    output logic [fctex_pkg::COORD_BITS-1:0]     o_tx,
    output logic [fctex_pkg::COORD_BITS-1:0]     o_ty
);
    localparam int NM = fctex_pkg::MOD_STG;
    localparam int NS = NM + 2;
    localparam int NB = fctex_pkg::STEPS;
    localparam int RW = fctex_pkg::REM_W;
    localparam int GW = fctex_pkg::MAG_W;
    localparam int CB = fctex_pkg::COORD_BITS;

    logic [NS-1:0]     r_v;
    fctex_pkg::t_meta  r_meta [NS];
    fctex_pkg::t_modw  r_x    [NM+1];
    fctex_pkg::t_modw  r_y    [NM+1];
    logic [CB-1:0]     r_tx;
    logic [CB-1:0]     r_ty;

    logic [NS:0]       w_rdy;
    logic [NS-1:0]     w_v_src;
    fctex_pkg::t_meta  w_m_src [NS];
    fctex_pkg::t_modw  n_x     [NM+1];
    fctex_pkg::t_modw  n_y     [NM+1];
    logic [RW-1:0]     w_mx;
    logic [RW-1:0]     w_my;
    logic signed [GW-1:0] w_ex;
    logic signed [GW-1:0] w_ey;
    logic [RW-1:0]     w_rx;
    logic [RW-1:0]     w_ry;
    logic [CB-1:0]     n_tx;
    logic [CB-1:0]     n_ty;

    assign w_mx = RW'(fctex_pkg::fn_clamp_size(i_cfg.texture_width));
    assign w_my = RW'(fctex_pkg::fn_clamp_size(i_cfg.texture_height));

    assign w_v_src    = {r_v[NS-2:0], i_valid};
    assign w_m_src[0] = i_meta;
    for (genvar k = 1; k < NS; k++) begin : g_src
        assign w_m_src[k] = r_meta[k-1];
    end

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end
    assign o_ready = w_rdy[0];

    // entry: sign and magnitude
    assign w_ex = GW'(i_fx);
    assign w_ey = GW'(i_fy);
    always_comb begin
        n_x[0].neg = i_fx < 0;
        n_x[0].rem = '0;
        n_x[0].mag = (i_fx < 0) ? GW'(-w_ex) : GW'(w_ex);
        n_y[0].neg = i_fy < 0;
        n_y[0].rem = '0;
        n_y[0].mag = (i_fy < 0) ? GW'(-w_ey) : GW'(w_ey);
    end

    always_comb begin
        fctex_pkg::t_modw cx;
        fctex_pkg::t_modw cy;
        logic [RW:0]      sx;
        logic [RW:0]      sy;
        for (int k = 1; k <= NM; k++) begin
            cx = r_x[k-1];
            cy = r_y[k-1];
            for (int j = 0; j < NB; j++) begin
                sx     = fctex_pkg::fn_rstep(cx.rem, cx.mag[GW-1], w_mx);
                cx.rem = sx[RW-1:0];
                cx.mag = {cx.mag[GW-2:0], 1'b0};
                sy     = fctex_pkg::fn_rstep(cy.rem, cy.mag[GW-1], w_my);
                cy.rem = sy[RW-1:0];
                cy.mag = {cy.mag[GW-2:0], 1'b0};
            end
            n_x[k] = cx;
            n_y[k] = cy;
        end
    end

    // negative value with a nonzero remainder folds back from the modulus
    assign w_rx = (r_x[NM].neg && r_x[NM].rem != '0) ? RW'(w_mx - r_x[NM].rem) : r_x[NM].rem;
    assign w_ry = (r_y[NM].neg && r_y[NM].rem != '0) ? RW'(w_my - r_y[NM].rem) : r_y[NM].rem;
    assign n_tx = r_meta[NS-2].ok ? w_rx[CB-1:0] : '0;
    assign n_ty = r_meta[NS-2].ok ? w_ry[CB-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_v_src[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (w_rdy[k] && w_v_src[k]) begin
                r_meta[k] <= w_m_src[k];
            end
        end
        for (int k = 0; k <= NM; k++) begin
            if (w_rdy[k] && w_v_src[k]) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
            end
        end
        if (w_rdy[NS-1] && w_v_src[NS-1]) begin
            r_tx <= n_tx;
            r_ty <= n_ty;
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_meta  = r_meta[NS-1];
    assign o_tx    = r_tx;
    assign o_ty    = r_ty;
endmodule
